// File: design/best_fit_block_allocator_unit_defines.svh
// Assertion macros used by the allocator's checker file.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

// File: design/bfa_pkg.sv
// Shared types and constants of the best-fit block allocator.
package bfa_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;
  localparam int CMD_FIFO_DEPTH = 2;

  // fixed field widths of the ports
  localparam int BIU_W   = 5;
  localparam int IDX_IN_W = 4;
  localparam int SIZE_IN_W = 16;

  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_REJECT = 2'd2
  } op_e_t;

  localparam int OP_W = 2;

  typedef struct packed {
    logic                 granted;
    logic [IDX_IN_W-1:0]  chosen_block;
    logic [SIZE_IN_W-1:0] leftover;
  } res_t;

endpackage

// File: design/bfa_cmd_fifo.sv
// Small command queue between the front and the back of the allocator.
module bfa_cmd_fifo
  import bfa_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/bfa_front.sv
// Front end: takes input transactions and classifies them into queue commands.
module bfa_front
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  localparam int CMD_W     = OP_W + IDX_IN_W + SIZE_BITS
) (
  input  logic                 in_push,
  input  logic                 in_command,
  input  logic [IDX_IN_W-1:0]  in_block_index,
  input  logic [SIZE_IN_W-1:0] in_size_value,
  output logic                 in_full,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [CMD_W-1:0]     q_data
);

  op_e_t                op;
  logic [SIZE_BITS-1:0] size;

  // sizes wider than the store lose their upper bits
  assign size = SIZE_BITS'(in_size_value);

  always_comb begin
    if (in_command == CMD_ALLOC) begin
      op = OP_ALLOC;
    end else if (32'(in_block_index) < NUM_BLOCKS) begin
      op = OP_LOAD;
    end else begin
      op = OP_REJECT;
    end
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;
  assign q_data  = {op, in_block_index, size};

endmodule

// File: design/bfa_back.sv
// Back end: free-space table, best-fit scan and table update.
module bfa_back
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  localparam int CMD_W     = OP_W + IDX_IN_W + SIZE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [BIU_W-1:0] blocks_in_use,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  output logic             res_valid,
  output res_t             res,
  input  logic             res_ready
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // table storage; an entry never written reads as zero through its valid bit
  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;
  logic [SIZE_BITS-1:0]  rd_q_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;

  op_e_t                 cmd_op;
  logic [IDX_IN_W-1:0]   cmd_idx;
  logic [SIZE_BITS-1:0]  cmd_size;

  logic [SIZE_BITS-1:0]  size_r, size_nxt;
  logic [CNT_W-1:0]      limit_r, limit_nxt;
  logic [CNT_W-1:0]      lim;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0]  best_f_r, best_f_nxt;
  logic                  found_r, found_nxt;

  logic [SIZE_BITS-1:0]  cur_f;
  logic                  hit;
  logic                  last;
  logic [SIZE_BITS-1:0]  left;

  assign cmd_op   = op_e_t'(cmd_data[CMD_W-1 -: OP_W]);
  assign cmd_idx  = cmd_data[SIZE_BITS +: IDX_IN_W];
  assign cmd_size = cmd_data[SIZE_BITS-1:0];

  assign lim = (32'(blocks_in_use) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_in_use);

  assign cur_f = rd_vld_r ? rd_q_r : '0;
  assign hit   = (cur_f >= size_r) && (!found_r || (cur_f < best_f_r));
  assign last  = ((CNT_W'(idx_r) + CNT_W'(1)) == limit_r);
  assign left  = best_f_r - size_r;

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    limit_nxt    = limit_r;
    idx_nxt      = idx_r;
    best_idx_nxt = best_idx_r;
    best_f_nxt   = best_f_r;
    found_nxt    = found_r;
    cmd_pop      = 1'b0;
    res_valid    = 1'b0;
    res          = '0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = IDX_W'(cmd_idx);
    wr_data      = cmd_size;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_op)
            OP_LOAD: begin
              res_valid        = 1'b1;
              res.granted      = 1'b1;
              res.chosen_block = cmd_idx;
              res.leftover     = SIZE_IN_W'(cmd_size);
              if (res_ready) begin
                cmd_pop = 1'b1;
                wr_en   = 1'b1;
              end
            end
            OP_ALLOC: begin
              // entry 0 is being read this cycle for the first compare
              cmd_pop    = 1'b1;
              size_nxt   = cmd_size;
              limit_nxt  = lim;
              idx_nxt    = '0;
              found_nxt  = 1'b0;
              best_idx_nxt = '0;
              best_f_nxt = '0;
              state_nxt  = (lim == '0) ? ST_FINISH : ST_SCAN;
            end
            default: begin
              // load to a missing entry: refused, all-zero result
              res_valid = 1'b1;
              if (res_ready) begin
                cmd_pop = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_nxt    = 1'b1;
          best_idx_nxt = idx_r;
          best_f_nxt   = cur_f;
        end
        if (last) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (found_r) begin
          res.granted      = 1'b1;
          res.chosen_block = IDX_IN_W'(best_idx_r);
          res.leftover     = SIZE_IN_W'(left);
        end
        wr_addr = best_idx_r;
        wr_data = left;
        if (res_ready) begin
          wr_en     = found_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    limit_r    <= limit_nxt;
    idx_r      <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_f_r   <= best_f_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

endmodule

// File: design/best_fit_block_allocator_unit.sv
// Top level of the best-fit block allocator.
//
//   channel  handshake            payload
//   input    in_push / in_full    in_command, in_block_index, in_size_value
//   result   out_pop / out_empty  out_granted, out_chosen_block, out_leftover
//   config   cfg_valid/cfg_ready  cfg_data (blocks in use)
//
// A load or a refused load is handled by the back end from its idle state; an
// allocate scans the entries in use, and the one read port of the free-space
// table lets the scan walk an entry per cycle.
// Reset (synchronous, rst_n low) empties the queues and marks all entries zero.
// The command queue keeps taking transactions, until it is full, while the back
// end scans or a result waits in the output register.
module best_fit_block_allocator_unit
  import bfa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_command,
  input  logic [IDX_IN_W-1:0]  in_block_index,
  input  logic [SIZE_IN_W-1:0] in_size_value,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_granted,
  output logic [IDX_IN_W-1:0]  out_chosen_block,
  output logic [SIZE_IN_W-1:0] out_leftover,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [BIU_W-1:0]     cfg_data
);

  localparam int CMD_W = OP_W + IDX_IN_W + SIZE_BITS;

  logic             q_push, q_full, q_pop, q_empty;
  logic [CMD_W-1:0] q_wdata, q_rdata;
  logic             res_valid, res_ready;
  res_t             res;

  logic [BIU_W-1:0] biu_r;
  logic             out_valid_r;
  res_t             out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      biu_r <= BIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      biu_r <= cfg_data;
    end
  end

  bfa_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_front (
    .in_push        (in_push),
    .in_command     (in_command),
    .in_block_index (in_block_index),
    .in_size_value  (in_size_value),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  bfa_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  bfa_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .blocks_in_use (biu_r),
    .cmd_valid     (!q_empty),
    .cmd_data      (q_rdata),
    .cmd_pop       (q_pop),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  // output register: refills in the cycle the waiting result is popped
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_granted      = out_r.granted;
  assign out_chosen_block = out_r.chosen_block;
  assign out_leftover     = out_r.leftover;

endmodule

// File: design/bfa_checker.sv
// Port-level checks of the allocator and their binding to the top level.
`include "best_fit_block_allocator_unit_defines.svh"

module bfa_checker
  import bfa_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic                 out_granted,
  input logic [IDX_IN_W-1:0]  out_chosen_block,
  input logic [SIZE_IN_W-1:0] out_leftover
);

  res_t out_bus;
  logic out_fields_zero;

  assign out_bus         = {out_granted, out_chosen_block, out_leftover};
  assign out_fields_zero = (out_chosen_block == '0) && (out_leftover == '0);

  // a waiting result holds until it is taken
  `BFA_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_bus))

  // a refusal carries no block and no leftover
  `BFA_ASSERT_IMPL(a_refuse_zero, clk, rst_n, !out_empty && !out_granted, out_fields_zero)

  // coming out of reset the output queue is empty and the input queue is not full
  `BFA_ASSERT_IMPL(a_reset_empty, clk, rst_n, $past(!rst_n), out_empty && !in_full)

endmodule

bind best_fit_block_allocator_unit bfa_checker u_bfa_checker (.*);
